### hdl/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and constants of the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int CAPACITY_MAX = 1024;

   localparam int DATA_W = 32;
   localparam int POS_W  = 5;
   localparam int LEN_W  = 5;
   localparam int STAT_W = 2;
   localparam int MODE_W = 3;

   // Wide enough for any index or length up to the largest capacity.
   localparam int IDX_W = $clog2(CAPACITY_MAX + 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_GET    = 3'd0,
      MODE_INSERT = 3'd1,
      MODE_HEAD   = 3'd2,
      MODE_TAIL   = 3'd3,
      MODE_DELETE = 3'd4
   } ile_mode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } ile_status_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } ile_op_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      ile_op_type        op;
      logic [IDX_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } ile_cmd_type;

endpackage

### hdl/ile_cell.sv
// ----------------------------------------------------------------------------
// ile_cell
// One list entry. Holds, loads the new word, or takes a neighbor's word.
// ----------------------------------------------------------------------------
module ile_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                      clock,
   input  ile_pkg::ile_cmd_type      cmd,
   input  logic [ile_pkg::DATA_W-1:0] left_data,
   input  logic [ile_pkg::DATA_W-1:0] right_data,
   output logic [ile_pkg::DATA_W-1:0] data
);
   import ile_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              at_pos;
   logic              past_pos;

   assign at_pos   = (CELL_INDEX == int'(cmd.pos));
   assign past_pos = (CELL_INDEX > int'(cmd.pos));

   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         OP_INSERT: begin
            if (at_pos) begin
               data_in = cmd.value;
            end else if (past_pos) begin
               data_in = left_data;
            end
         end
         OP_DELETE: begin
            if (at_pos || past_pos) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

### hdl/indexed_list_engine_unit.sv
// ----------------------------------------------------------------------------
// indexed_list_engine_unit
// Ordered list of signed 32-bit words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// The result word is registered at acceptance and appears in the next cycle.
// One request per cycle while the result register is empty or being emptied;
// the row of cells shifts up, shifts down or is read as each request is taken.
// Reset clears the length and empties the result register; cell contents stay
// undefined until written, and no clearing pass is needed.
module indexed_list_engine_unit #(
   parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ile_pkg::MODE_W-1:0]  req_mode,
   input  logic [ile_pkg::POS_W-1:0]   req_position,
   input  logic signed [ile_pkg::DATA_W-1:0] req_item_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ile_pkg::STAT_W-1:0]  rsp_status,
   output logic signed [ile_pkg::DATA_W-1:0] rsp_read_value,
   output logic [ile_pkg::LEN_W-1:0]   rsp_length
);
   import ile_pkg::*;

   // The count must be able to hold the capacity itself.
   localparam int CNT_W = $clog2(CAPACITY + 1);
   // A position word can only name the first 2**POS_W cells.
   localparam int READ_N = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   ile_status_type    rsp_status_ff;
   ile_status_type    rsp_status_in;
   logic [DATA_W-1:0] rsp_read_value_ff;
   logic [DATA_W-1:0] rsp_read_value_in;
   logic [LEN_W-1:0]  rsp_length_ff;
   logic [LEN_W-1:0]  rsp_length_in;

   logic              accept;
   logic [IDX_W-1:0]  pos_w;
   logic [IDX_W-1:0]  cnt_w;
   logic [IDX_W-1:0]  target;
   logic              full;
   logic [DATA_W-1:0] read_word;
   ile_status_type    status;
   ile_op_type        op;
   logic [CNT_W-1:0]  count_next;
   ile_cmd_type       cmd;

   logic [DATA_W-1:0] cell_q [CAPACITY];

   // A new word is taken whenever the result register is empty or is being
   // emptied in this same cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign pos_w = IDX_W'(req_position);
   assign cnt_w = IDX_W'(count_ff);
   assign full  = (count_ff == CNT_W'(CAPACITY));

   // Read port: each addressable cell drives the bus when it is selected.
   always_comb begin
      read_word = '0;
      for (int i = 0; i < READ_N; i++) begin
         if (POS_W'(i) == req_position) begin
            read_word = read_word | cell_q[i];
         end
      end
   end

   // Decode the request into a status, a row command and the new length.
   always_comb begin
      status            = ST_RANGE;
      op                = OP_HOLD;
      count_next        = count_ff;
      rsp_read_value_in = '1;
      target            = pos_w;
      case (ile_mode_type'(req_mode))
         MODE_GET: begin
            if (pos_w < cnt_w) begin
               status            = ST_DONE;
               rsp_read_value_in = read_word;
            end
         end
         MODE_INSERT, MODE_HEAD, MODE_TAIL: begin
            if (ile_mode_type'(req_mode) == MODE_HEAD) begin
               target = '0;
            end else if (ile_mode_type'(req_mode) == MODE_TAIL) begin
               target = cnt_w;
            end
            // The index check comes before the full check.
            if (target > cnt_w) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               status     = ST_DONE;
               op         = OP_INSERT;
               count_next = count_ff + CNT_W'(1);
            end
         end
         MODE_DELETE: begin
            if (pos_w < cnt_w) begin
               status     = ST_DONE;
               op         = OP_DELETE;
               count_next = count_ff - CNT_W'(1);
            end
         end
         default: begin
            status = ST_RANGE;
         end
      endcase
   end

   // The row only moves on an accepted word.
   always_comb begin
      cmd.op    = accept ? op : OP_HOLD;
      cmd.pos   = target;
      cmd.value = req_item_value;
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic [DATA_W-1:0] left_w;
         logic [DATA_W-1:0] right_w;
         if (g == 0) begin : g_first
            assign left_w = '0;
         end else begin : g_mid_l
            assign left_w = cell_q[g-1];
         end
         if (g == CAPACITY - 1) begin : g_last
            assign right_w = '0;
         end else begin : g_mid_r
            assign right_w = cell_q[g+1];
         end
         ile_cell #(
            .CELL_INDEX (g)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_q[g])
         );
      end
   endgenerate

   // Next values of the count and the result register. The reported length
   // keeps the low bits of the count.
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = status;
      rsp_length_in = LEN_W'(count_next);
      if (accept) begin
         count_in     = count_next;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         rsp_status_ff     <= rsp_status_in;
         rsp_read_value_ff <= rsp_read_value_in;
         rsp_length_ff     <= rsp_length_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_length     = rsp_length_ff;

endmodule

### hdl/ile_checker.sv
// ----------------------------------------------------------------------------
// ile_checker
// Port-level assertions for the indexed list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ile_checker #(
   parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [ile_pkg::STAT_W-1:0]  rsp_status,
   input logic [ile_pkg::DATA_W-1:0]  rsp_read_value,
   input logic [ile_pkg::LEN_W-1:0]   rsp_length
);
   import ile_pkg::*;

   localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(CAPACITY);

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present after reset");

   // Every accepted request yields a result word in the next cycle.
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted request produced no result word");

   // A full status is only reported when the reported length equals the capacity.
   a_full_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_length == FULL_LEN))
      else $error("full status with a length below capacity");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_read_value)
          && $stable(rsp_length)))
      else $error("stalled result word changed");

endmodule

bind indexed_list_engine_unit ile_checker #(.CAPACITY(CAPACITY)) u_ile_checker (.*);

### test/indexed_list_engine_unit_test.sv
// ----------------------------------------------------------------------------
// indexed_list_engine_unit_test
// Self-checking bench for the indexed list engine. A driver and a monitor run
// off the clock edge. A shadow copy of the list predicts the status, the read
// word and the length for every accepted request. Directed requests come
// first, then random requests, through phases with different idle patterns.
// ----------------------------------------------------------------------------
module indexed_list_engine_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   import ile_pkg::*;

   localparam int LIST_CAPACITY = CAPACITY_DEF;
   localparam int CYCLE_LIMIT   = 200_000;
   localparam int PHASE_ITEMS   = 412;

   // Modes 5 to 7 are not defined. The engine must report them as out of
   // range and leave the list alone.
   localparam logic [MODE_W-1:0] MODE_UNKNOWN_LO = 3'd5;
   localparam logic [MODE_W-1:0] MODE_UNKNOWN_HI = 3'd7;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } list_request_type;

   typedef struct {
      ile_status_type    status;
      logic [DATA_W-1:0] read_value;
      logic [LEN_W-1:0]  length;
   } list_result_type;

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_ready;
   logic [MODE_W-1:0]        req_mode       = '0;
   logic [POS_W-1:0]         req_position   = '0;
   logic signed [DATA_W-1:0] req_item_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready      = 1'b0;
   logic [STAT_W-1:0]        rsp_status;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [LEN_W-1:0]         rsp_length;

   // Requests waiting for the driver, and results waiting for the monitor.
   list_request_type pending_requests[$];
   list_result_type  expected_results[$];

   // Shadow copy of the list contents and length, updated at acceptance.
   logic [DATA_W-1:0] list_cells [LIST_CAPACITY];
   int                list_len = 0;

   // Length the stimulus generator assumes, used to aim positions and to steer the mix.
   int gen_len = 0;

   int idle_pct    = 0;
   int stall_pct   = 0;
   int fail_count  = 0;
   int cycle_count = 0;

   indexed_list_engine_unit #(
      .CAPACITY(LIST_CAPACITY)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_length     (rsp_length)
   );

   // 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Applies one operation to the shadow list and returns the result word that
   // the engine must send back for it. Index checks come before the full check,
   // so an insert past the end of a full list reports out of range.
   function automatic list_result_type apply_list_op(input logic [MODE_W-1:0] mode,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [DATA_W-1:0] value);
      list_result_type res;
      int              at;
      res.status     = ST_DONE;
      res.read_value = '1;
      at             = pos;
      case (mode)
         MODE_GET: begin
            if (at < list_len) begin
               res.read_value = list_cells[at];
            end else begin
               res.status = ST_RANGE;
            end
         end
         MODE_INSERT, MODE_HEAD, MODE_TAIL: begin
            if (mode == MODE_HEAD) begin
               at = 0;
            end else if (mode == MODE_TAIL) begin
               at = list_len;
            end
            if (at > list_len) begin
               res.status = ST_RANGE;
            end else if (list_len >= LIST_CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               for (int i = list_len; i > at; i--) begin
                  list_cells[i] = list_cells[i-1];
               end
               list_cells[at] = value;
               list_len++;
            end
         end
         MODE_DELETE: begin
            if (at >= list_len) begin
               res.status = ST_RANGE;
            end else begin
               for (int i = at; i + 1 < list_len; i++) begin
                  list_cells[i] = list_cells[i+1];
               end
               list_len--;
            end
         end
         default: begin
            res.status = ST_RANGE;
         end
      endcase
      res.length = list_len[LEN_W-1:0];
      return res;
   endfunction

   // Queues one request and keeps the generator's idea of the length current.
   task automatic queue_op(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                           input logic [DATA_W-1:0] value);
      list_request_type item;
      item.mode  = mode;
      item.pos   = pos;
      item.value = value;
      pending_requests.push_back(item);
      case (mode)
         MODE_INSERT: begin
            if (pos <= gen_len && gen_len < LIST_CAPACITY) gen_len++;
         end
         MODE_HEAD, MODE_TAIL: begin
            if (gen_len < LIST_CAPACITY) gen_len++;
         end
         MODE_DELETE: begin
            if (pos < gen_len) gen_len--;
         end
         default: begin
         end
      endcase
   endtask

   // Mostly a valid index up to the limit; now and then anything the five-bit
   // field can hold, so the upper position bit toggles too.
   function automatic logic [POS_W-1:0] pick_pos(input int limit);
      if (limit < 0 || $urandom_range(0, 9) == 0) begin
         return POS_W'($urandom_range(0, 31));
      end
      return POS_W'($urandom_range(0, limit));
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 39))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Random traffic that sweeps the list between empty and full. Inserts
   // dominate while growing and deletes while shrinking, so both ends of the
   // list are reached many times, with gets and a little noise mixed in.
   task automatic queue_random_phase(input int n_items);
      bit grow;
      int r;
      grow = 1'b1;
      for (int k = 0; k < n_items; k++) begin
         if (gen_len >= LIST_CAPACITY && $urandom_range(0, 3) == 0) begin
            grow = 1'b0;
         end else if (gen_len == 0 && $urandom_range(0, 1) == 0) begin
            grow = 1'b1;
         end else if (k % 30 == 0 && $urandom_range(0, 3) == 0) begin
            grow = !grow;
         end
         r = $urandom_range(0, 99);
         if (r < 5) begin
            queue_op(MODE_W'($urandom_range(MODE_UNKNOWN_LO, MODE_UNKNOWN_HI)),
                     POS_W'($urandom_range(0, 31)), $urandom);
         end else if (r < 25) begin
            queue_op(MODE_GET, pick_pos(gen_len - 1), pick_value());
         end else if (r < (grow ? 70 : 45)) begin
            case ($urandom_range(0, 2))
               0:       queue_op(MODE_INSERT, pick_pos(gen_len), pick_value());
               1:       queue_op(MODE_HEAD, POS_W'($urandom_range(0, 31)), pick_value());
               default: queue_op(MODE_TAIL, POS_W'($urandom_range(0, 31)), pick_value());
            endcase
         end else begin
            queue_op(MODE_DELETE, pick_pos(gen_len - 1), pick_value());
         end
      end
   endtask

   // Request driver. A word that is offered stays on the port unchanged until
   // it is taken. The expected result is worked out at the edge where the word
   // is accepted, from the values the engine saw at that edge.
   always @(posedge clock) begin : request_driver
      list_request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(apply_list_op(req_mode, req_position,
                                                     req_item_value));
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               next_req = pending_requests.pop_front();
               req_valid      <= 1'b1;
               req_mode       <= next_req.mode;
               req_position   <= next_req.pos;
               req_item_value <= next_req.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor. Every accepted result word is checked field by field
   // against the oldest expectation; rsp_ready is rolled anew every cycle.
   always @(posedge clock) begin : result_monitor
      list_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result word, expected none, got status %0d",
                        $time, rsp_status);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_read_value !== want.read_value) begin
                  $display("%0t: read_value mismatch, expected %h, got %h",
                           $time, want.read_value, rsp_read_value);
                  fail_count++;
               end
               if (rsp_length !== want.length) begin
                  $display("%0t: length mismatch, expected %0d, got %0d",
                           $time, want.length, rsp_length);
                  fail_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** indexed_list_engine_unit: FAILED **");
         $finish;
      end
   end

   // Blocks until every queued word has gone through and its result came back.
   task automatic wait_for_drain();
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the empty list: get, delete and insert past the end.
      queue_op(MODE_GET, 5'd0, 32'h0);
      queue_op(MODE_DELETE, 5'd0, 32'h0);
      queue_op(MODE_INSERT, 5'd1, 32'h1234_5678);
      // Build a short list with the value extremes through every insert mode.
      queue_op(MODE_INSERT, 5'd0, 32'h7FFF_FFFF);
      queue_op(MODE_HEAD, 5'd31, 32'h8000_0000);
      queue_op(MODE_TAIL, 5'd16, 32'h0000_0000);
      queue_op(MODE_INSERT, 5'd1, 32'hFFFF_FFFF);
      queue_op(MODE_GET, 5'd1, 32'h0);
      queue_op(MODE_GET, 5'd3, 32'h0);
      queue_op(MODE_GET, 5'd4, 32'h0);
      // Undefined modes do nothing.
      queue_op(MODE_UNKNOWN_LO, 5'd31, 32'hFFFF_FFFF);
      queue_op(MODE_UNKNOWN_HI, 5'd0, 32'h0);
      // Fill to capacity, then try every kind of insert on the full list;
      // the one past the end must report out of range, not full.
      while (gen_len < LIST_CAPACITY) begin
         queue_op(MODE_TAIL, 5'd0, $urandom);
      end
      queue_op(MODE_HEAD, 5'd0, 32'h5555_5555);
      queue_op(MODE_INSERT, 5'd17, 32'hAAAA_AAAA);
      queue_op(MODE_TAIL, 5'd0, 32'h0);
      queue_op(MODE_GET, 5'd15, 32'h0);
      queue_op(MODE_GET, 5'd31, 32'h0);
      // Delete the last entry, then the first.
      queue_op(MODE_DELETE, 5'd15, 32'h0);
      queue_op(MODE_DELETE, 5'd0, 32'h0);

      // Phase one: no idling on either side.
      idle_pct  = 0;
      stall_pct = 0;
      queue_random_phase(PHASE_ITEMS);
      wait_for_drain();

      // Phase two: the sender leaves gaps most of the time.
      idle_pct  = 65;
      stall_pct = 0;
      queue_random_phase(PHASE_ITEMS);
      wait_for_drain();

      // Phase three: the receiver holds off most of the time.
      idle_pct  = 0;
      stall_pct = 65;
      queue_random_phase(PHASE_ITEMS);
      wait_for_drain();

      // Phase four: light idling on both sides at once.
      idle_pct  = 16;
      stall_pct = 16;
      queue_random_phase(PHASE_ITEMS);
      wait_for_drain();

      // The result comes in the cycle after acceptance; the final wait catches
      // any stray result word.
      repeat (4) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_results.size());
         fail_count++;
      end

      if (fail_count == 0) begin
         $display("** indexed_list_engine_unit: PASSED **");
      end else begin
         $display("** indexed_list_engine_unit: FAILED **");
      end
      $finish;
   end

endmodule
